FILE: src/rrwp_pkg.sv
// ============================================================================
// rrwp_pkg
// Types and constants shared by the ring record writer pointer block.
// ============================================================================
package rrwp_pkg;

  localparam int unsigned OffsetBits  = 24;
  localparam int unsigned PtrBits     = OffsetBits + 1;
  localparam int unsigned SumBits     = OffsetBits + 2;
  localparam int unsigned HeaderBytes = 8;
  localparam logic [OffsetBits-1:0] BufSizeReset = OffsetBits'(65512);

  // actions
  localparam logic [2:0] ActWrite   = 3'd0;
  localparam logic [2:0] ActWriteNp = 3'd1;
  localparam logic [2:0] ActPublish = 3'd2;
  localparam logic [2:0] ActReserve = 3'd3;
  localparam logic [2:0] ActFinish  = 3'd4;

  // status codes
  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StNoRdr   = 3'd1;
  localparam logic [2:0] StStarted = 3'd2;
  localparam logic [2:0] StFull    = 3'd3;
  localparam logic [2:0] StError   = 3'd4;

  typedef struct packed {
    logic [2:0]            action;
    logic [OffsetBits-1:0] record_length;
    logic [OffsetBits-1:0] read_offset;
    logic                  read_page;
    logic                  reader_started;
    logic                  reader_inactive;
  } rrwp_req_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [OffsetBits-1:0] header_offset;
    logic [OffsetBits-1:0] payload_offset;
    logic [OffsetBits-1:0] stored_length;
    logic                  header_write;
    logic                  tail_mark_write;
    logic [OffsetBits-1:0] tail_mark_offset;
    logic                  publish_valid;
    logic [PtrBits-1:0]    publish_pointer;
    logic                  reader_reset;
  } rrwp_res_t;

  typedef struct packed {
    logic [PtrBits-1:0]    published_pointer;
    logic                  writer_locked;
    logic [PtrBits-1:0]    pending_pointer;
    logic                  pending_flag;
    logic [OffsetBits-1:0] reserved_offset;
    logic                  reserved_page;
    logic                  reservation_open;
  } rrwp_state_t;

endpackage

FILE: src/rrwp_step.sv
// ============================================================================
// rrwp_step
// Combinational request decode: next writer state and result beat.
// ============================================================================
module rrwp_step import rrwp_pkg::*; (
  input  rrwp_req_t             req_i,
  input  rrwp_state_t           state_i,
  input  logic [OffsetBits-1:0] buf_size_i,
  output rrwp_state_t           state_o,
  output rrwp_res_t             res_o
);

  logic [SumBits-1:0]    len_ext;
  logic [SumBits-1:0]    leng;
  logic [SumBits-1:0]    rpt_ext;
  logic [SumBits-1:0]    bsz_ext;
  logic [SumBits-1:0]    sum;
  logic [SumBits-1:0]    csum;
  logic [PtrBits-1:0]    ptr;
  logic [PtrBits-1:0]    newp;
  logic [OffsetBits-1:0] wpt;
  logic                  wpg;
  logic [OffsetBits-1:0] cwpt;
  logic                  cwpg;
  logic                  commit;
  logic                  full_here;
  logic                  fold;
  logic                  full_fold;

  assign len_ext = {2'b00, req_i.record_length} + SumBits'(HeaderBytes + 3);
  assign leng    = {len_ext[SumBits-1:2], 2'b00};
  assign rpt_ext = {2'b00, req_i.read_offset};
  assign bsz_ext = {2'b00, buf_size_i};

  // pending pointer wins; on a write it was just flushed to the same value
  assign ptr = state_i.pending_flag ? state_i.pending_pointer : state_i.published_pointer;
  assign wpg = ptr[OffsetBits];
  assign wpt = ptr[OffsetBits-1:0];
  assign sum = {2'b00, wpt} + leng;

  assign full_here = (req_i.read_page != wpg) && (sum >= rpt_ext);
  assign fold      = sum > bsz_ext;
  assign full_fold = (req_i.read_page == wpg) && (leng >= rpt_ext);

  always_comb begin
    state_o = state_i;
    res_o   = '0;
    commit  = 1'b0;
    cwpt    = wpt;
    cwpg    = wpg;
    csum    = '0;
    newp    = '0;

    priority if (req_i.action > ActFinish) begin
      res_o.status = StError;
    end else if (state_i.reservation_open) begin
      if (req_i.action != ActFinish) begin
        res_o.status = StError;
      end else begin
        state_o.reservation_open = 1'b0;
        cwpt   = state_i.reserved_offset;
        cwpg   = state_i.reserved_page;
        commit = 1'b1;
      end
    end else if (req_i.action == ActFinish) begin
      res_o.status = StOk;
    end else begin
      if (state_i.pending_flag &&
          (req_i.action == ActWrite || req_i.action == ActPublish)) begin
        state_o.published_pointer = state_i.pending_pointer;
        state_o.pending_flag      = 1'b0;
        res_o.publish_valid       = 1'b1;
        res_o.publish_pointer     = state_i.pending_pointer;
      end
      priority if (req_i.action == ActPublish) begin
        res_o.status = StOk;
      end else if (req_i.reader_started) begin
        state_o.published_pointer = '0;
        state_o.pending_flag      = 1'b0;
        state_o.writer_locked     = 1'b0;
        res_o.status              = StStarted;
        res_o.publish_valid       = 1'b1;
        res_o.publish_pointer     = '0;
        res_o.reader_reset        = 1'b1;
      end else if (state_i.writer_locked || req_i.reader_inactive) begin
        res_o.status = StNoRdr;
      end else if (full_here || (fold && full_fold)) begin
        res_o.status = StFull;
      end else begin
        if (fold) begin
          res_o.tail_mark_write  = 1'b1;
          res_o.tail_mark_offset = wpt;
          cwpt = '0;
          cwpg = ~wpg;
        end
        if (fold && (leng > bsz_ext)) begin
          res_o.status = StError;
        end else if (req_i.action == ActReserve) begin
          state_o.reservation_open = 1'b1;
          state_o.reserved_offset  = cwpt;
          state_o.reserved_page    = cwpg;
          res_o.header_offset      = cwpt;
          res_o.payload_offset     = cwpt + OffsetBits'(HeaderBytes);
          res_o.stored_length      = leng[OffsetBits-1:0];
        end else begin
          commit = 1'b1;
        end
      end
    end

    if (commit) begin
      // plain sum, carry may flip the page
      csum = {2'b00, cwpt} + leng;
      newp = csum[PtrBits-1:0] + {cwpg, {OffsetBits{1'b0}}};
      res_o.header_offset  = cwpt;
      res_o.payload_offset = cwpt + OffsetBits'(HeaderBytes);
      res_o.stored_length  = leng[OffsetBits-1:0];
      res_o.header_write   = 1'b1;
      if (req_i.action == ActWriteNp) begin
        state_o.pending_pointer = newp;
        state_o.pending_flag    = 1'b1;
      end else begin
        state_o.published_pointer = newp;
        if (req_i.action == ActFinish) begin
          state_o.pending_flag = 1'b0;
        end
        res_o.publish_valid   = 1'b1;
        res_o.publish_pointer = newp;
      end
    end
  end

endmodule

FILE: src/ring_record_writer_pointer.sv
// ============================================================================
// ring_record_writer_pointer
// Producer-side pointer keeper for a ring of length-prefixed records.
// ============================================================================
// One request is taken per clock cycle (busy_o stays low) and its result
// beat shows on res_o, flagged by done_o, for exactly one cycle. The request
// is first captured in the request register, then goes through the decode
// into the result register. Writer state updates in the same cycle as the
// decode, so back-to-back requests see each other's effects. The receiver
// cannot stall; it must take every beat. The user writes buffer_size with
// cfg_we_i only while no request is in flight; the block does not enforce it.
module ring_record_writer_pointer import rrwp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  rrwp_req_t             req_i,
  input  logic                  cfg_we_i,
  input  logic [OffsetBits-1:0] cfg_wdata_i,
  output logic                  done_o,
  output rrwp_res_t             res_o
);

  logic                  vld_q;
  rrwp_req_t             req_q;
  logic                  done_q;
  rrwp_res_t             res_q;
  rrwp_res_t             res_d;
  rrwp_state_t           state_q;
  rrwp_state_t           state_d;
  logic [OffsetBits-1:0] bsz_q;

  assign busy_o = 1'b0;

  rrwp_step u_step (
    .req_i      (req_q),
    .state_i    (state_q),
    .buf_size_i (bsz_q),
    .state_o    (state_d),
    .res_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      done_q  <= 1'b0;
      bsz_q   <= BufSizeReset;
      state_q <= '{writer_locked: 1'b1, default: '0};
    end else begin
      vld_q  <= start_i;
      done_q <= vld_q;
      if (cfg_we_i) begin
        bsz_q <= cfg_wdata_i;
      end
      if (vld_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      req_q <= req_i;
    end
    if (vld_q) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_done_follows_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(vld_q))
    else $error("result beat without request");

  a_hdr_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.header_write) |-> (res_o.status == StOk))
    else $error("header written with bad status");

  a_rdr_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.reader_reset) |->
      (res_o.publish_valid && res_o.publish_pointer == '0 && res_o.status == StStarted))
    else $error("reader reset without pointer clear");

  a_tail_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.tail_mark_write) |-> (res_o.status == StOk || res_o.status == StError))
    else $error("tail mark with wrong status");

endmodule
